// ===== rtl/psc_pkg.sv =====
// Shared types, constants and helpers for the sensor compensation pipeline.
// No dependencies; used by every module of the block but psc_delay.
package psc_pkg;

    // Widths of the stream fields
    localparam int RawPW        = 20;
    localparam int RawTW        = 20;
    localparam int RawHW        = 16;
    localparam int HumW         = 17;
    localparam int InTdataW     = 56;
    localparam int OutTdataW    = 120;
    localparam int CalibW       = 64;
    localparam int CfgIdxW      = 2;

    // Pipeline depths
    localparam int TfLat        = 4;
    localparam int TempLat      = 5;
    localparam int DivStages    = 32;
    localparam int PressLat     = 43;
    localparam int HumLat       = 10;
    localparam int TotalLat     = TfLat + PressLat;

    // Formula constants
    localparam logic [31:0] K_P_OFFSET   = 32'd64000;
    localparam logic [31:0] K_P_FULL     = 32'd1048576;
    localparam logic [31:0] K_P_SCALE    = 32'd3125;
    localparam logic [31:0] K_H_OFFSET   = 32'd76800;
    localparam logic [31:0] K_H_MAX      = 32'h1900_0000;
    localparam logic [31:0] K_H_BIAS     = 32'd2097152;
    localparam logic [31:0] K_32768      = 32'd32768;
    localparam logic [31:0] K_16384      = 32'd16384;
    localparam logic [31:0] K_8192       = 32'd8192;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_TEMP       = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_HUMID      = 2'd3
    } cfg_idx_t;

    // Calibration words, all extended to 32 bits
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } calib_t;

    // Arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Unpack the four calibration registers
    function automatic calib_t calib_decode(input logic [CalibW-1:0] ct,
                                            input logic [CalibW-1:0] cpl,
                                            input logic [CalibW-1:0] cph,
                                            input logic [CalibW-1:0] ch);
        calib_t c;
        c.t1 = {16'd0, ct[15:0]};
        c.t2 = sx16(ct[31:16]);
        c.t3 = sx16(ct[47:32]);
        c.p9 = sx16(ct[63:48]);
        c.p1 = {16'd0, cpl[15:0]};
        c.p2 = sx16(cpl[31:16]);
        c.p3 = sx16(cpl[47:32]);
        c.p4 = sx16(cpl[63:48]);
        c.p5 = sx16(cph[15:0]);
        c.p6 = sx16(cph[31:16]);
        c.p7 = sx16(cph[47:32]);
        c.p8 = sx16(cph[63:48]);
        c.h1 = {24'd0, ch[7:0]};
        c.h2 = sx16(ch[23:8]);
        c.h3 = {24'd0, ch[31:24]};
        c.h4 = {{20{ch[43]}}, ch[43:32]};
        c.h5 = {{20{ch[55]}}, ch[55:44]};
        c.h6 = {{24{ch[63]}}, ch[63:56]};
        return c;
    endfunction

endpackage

// ===== rtl/pth_sensor_compensation.sv =====
// Pressure, temperature and humidity compensation with integer formulas.
// One item per cycle sustained while the output is not stalled, set by the fully
// pipelined datapath and its 32-stage bit-per-stage divider.
// A stalled output holds the whole pipeline in place.
// Reset (rst_n, asynchronous) empties the pipeline and clears the calibration.
module pth_sensor_compensation
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // raw_pressure [19:0], raw_temperature [39:20], raw_humidity [55:40]
    input  logic [InTdataW-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // temperature [31:0], fine_temperature [63:32], pressure [95:64], humidity [112:96]
    output logic [OutTdataW-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CalibW-1:0]    cfg_data
);

    logic [CalibW-1:0]   calib_temp_reg, calib_press_low_reg, calib_press_high_reg;
    logic [CalibW-1:0]   calib_humid_reg;
    logic [TotalLat-1:0] vld_reg;
    logic                en;
    calib_t              calib;
    logic [31:0]         tf, temp, press, tf_d, temp_d;
    logic [RawPW-1:0]    raw_p4;
    logic [RawHW-1:0]    raw_h4;
    logic [HumW-1:0]     hum, hum_d;

    // Calibration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_temp_reg       <= '0;
            calib_press_low_reg  <= '0;
            calib_press_high_reg <= '0;
            calib_humid_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TEMP:       calib_temp_reg       <= cfg_data;
                CFG_PRESS_LOW:  calib_press_low_reg  <= cfg_data;
                CFG_PRESS_HIGH: calib_press_high_reg <= cfg_data;
                CFG_HUMID:      calib_humid_reg      <= cfg_data;
                default:        calib_humid_reg      <= calib_humid_reg;
            endcase
        end
    end

    assign calib = calib_decode(calib_temp_reg, calib_press_low_reg,
                                calib_press_high_reg, calib_humid_reg);

    // Whole pipeline advances unless a finished item waits at the output
    assign en       = !vld_reg[TotalLat-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TotalLat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TotalLat-2:0], s_tvalid};
        end
    end

    psc_temp u_temp (
        .clk       (clk),
        .en        (en),
        .calib     (calib),
        .raw_p     (s_tdata[19:0]),
        .raw_t     (s_tdata[39:20]),
        .raw_h     (s_tdata[55:40]),
        .tf        (tf),
        .temp      (temp),
        .raw_p_out (raw_p4),
        .raw_h_out (raw_h4)
    );

    psc_press u_press (
        .clk   (clk),
        .en    (en),
        .calib (calib),
        .tf    (tf),
        .raw_p (raw_p4),
        .press (press)
    );

    psc_humid u_humid (
        .clk   (clk),
        .en    (en),
        .calib (calib),
        .tf    (tf),
        .raw_h (raw_h4),
        .hum   (hum)
    );

    // Align the shorter branches with the pressure result
    psc_delay #(.WIDTH(32), .DEPTH(TotalLat - TempLat)) u_dly_temp (
        .clk (clk), .en (en), .din (temp), .dout (temp_d)
    );

    psc_delay #(.WIDTH(32), .DEPTH(PressLat)) u_dly_tf (
        .clk (clk), .en (en), .din (tf), .dout (tf_d)
    );

    psc_delay #(.WIDTH(HumW), .DEPTH(PressLat - HumLat)) u_dly_hum (
        .clk (clk), .en (en), .din (hum), .dout (hum_d)
    );

    assign m_tdata = {7'd0, hum_d, press, tf_d, temp_d};

endmodule

// ===== rtl/psc_delay.sv =====
// Enable-gated delay line that aligns results of the parallel branches.
// Depends on nothing but its parameters.
module psc_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift the line by one place on every advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== rtl/psc_temp.sv =====
// Temperature stages: fine temperature after four stages, temperature after five.
// Depends on psc_pkg; carries the raw pressure and humidity alongside.
module psc_temp
    import psc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  calib_t           calib,
    input  logic [RawPW-1:0] raw_p,
    input  logic [RawTW-1:0] raw_t,
    input  logic [RawHW-1:0] raw_h,
    output logic [31:0]      tf,
    output logic [31:0]      temp,
    output logic [RawPW-1:0] raw_p_out,
    output logic [RawHW-1:0] raw_h_out
);

    logic [31:0]      a_reg, b_reg, m1_reg, m2_reg, v1_reg, m3_reg, tf_reg, temp_reg;
    logic [RawPW-1:0] rp_reg [4];
    logic [RawHW-1:0] rh_reg [4];
    logic [31:0]      adc_t;
    logic [31:0]      tf5;

    assign adc_t = {12'd0, raw_t};
    assign tf5   = (tf_reg << 2) + tf_reg + 32'd128;

    // Stage 1: offsets, stage 2: products, stage 3: cubic term, stage 4: sum, stage 5: temperature
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= (adc_t >> 3) - (calib.t1 << 1);
            b_reg    <= (adc_t >> 4) - calib.t1;
            m1_reg   <= a_reg * calib.t2;
            m2_reg   <= b_reg * b_reg;
            v1_reg   <= asr32(m1_reg, 11);
            m3_reg   <= asr32(m2_reg, 12) * calib.t3;
            tf_reg   <= v1_reg + asr32(m3_reg, 14);
            temp_reg <= asr32(tf5, 8);
            rp_reg[0] <= raw_p;
            rh_reg[0] <= raw_h;
            for (int i = 1; i < 4; i++)
            begin
                rp_reg[i] <= rp_reg[i-1];
                rh_reg[i] <= rh_reg[i-1];
            end
        end
    end

    assign tf        = tf_reg;
    assign temp      = temp_reg;
    assign raw_p_out = rp_reg[3];
    assign raw_h_out = rh_reg[3];

endmodule

// ===== rtl/psc_div.sv =====
// Unsigned 32-by-32 divider, one quotient bit per pipeline stage.
// Depends on psc_pkg; a small tag travels with each item.
module psc_div
    import psc_pkg::*;
#(
    parameter int TAGW = 2
) (
    input  logic            clk,
    input  logic            en,
    input  logic [31:0]     num,
    input  logic [31:0]     den,
    input  logic [TAGW-1:0] tag,
    output logic [31:0]     quo,
    output logic [TAGW-1:0] tag_out
);

    logic [31:0]     rem_reg [DivStages];
    logic [31:0]     quo_reg [DivStages];
    logic [31:0]     num_reg [DivStages];
    logic [31:0]     den_reg [DivStages];
    logic [TAGW-1:0] tag_reg [DivStages];

    for (genvar i = 0; i < DivStages; i++)
    begin : g_stage
        logic [31:0]     rem_in, quo_in, num_in, den_in;
        logic [TAGW-1:0] tag_in;
        logic [32:0]     trial, diff;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign tag_in = tag;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        // Shift in the next dividend bit and try a subtraction
        assign trial = {rem_in, num_in[31]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= diff[32] ? trial[31:0] : diff[31:0];
                quo_reg[i] <= {quo_in[30:0], ~diff[32]};
                num_reg[i] <= num_in << 1;
                den_reg[i] <= den_in;
                tag_reg[i] <= tag_in;
            end
        end
    end

    assign quo     = quo_reg[DivStages-1];
    assign tag_out = tag_reg[DivStages-1];

endmodule

// ===== rtl/psc_press.sv =====
// Pressure stages: polynomial terms, pipelined division and the final correction.
// Depends on psc_pkg and psc_div.
module psc_press
    import psc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  calib_t           calib,
    input  logic [31:0]      tf,
    input  logic [RawPW-1:0] raw_p,
    output logic [31:0]      press
);

    logic [31:0]      v1_reg, q_reg, qq_reg, m5_reg, m6_reg, v2a_reg, m7_reg;
    logic [31:0]      m5b_reg, m6b_reg, v2_reg, w_reg, m8_reg, num0_reg, dv_reg, pn_reg;
    logic [31:0]      dnum_reg, dden_reg;
    logic [1:0]       dtag_reg;
    logic [RawPW-1:0] rp_reg [4];
    logic [31:0]      quo;
    logic [1:0]       qtag;
    logic [31:0]      pq_reg, s_reg, m9_reg, pa_reg, pb_reg, am_reg, m9b_reg, out_reg;
    logic             zq_reg, za_reg, zb_reg;
    logic [31:0]      p8s, corr;

    // Stages 1 to 7: terms, divisor, numerator, dividend set-up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg   <= asr32(tf, 1) - K_P_OFFSET;
            q_reg    <= asr32(asr32(tf, 1) - K_P_OFFSET, 2);
            rp_reg[0] <= raw_p;
            for (int i = 1; i < 4; i++)
            begin
                rp_reg[i] <= rp_reg[i-1];
            end
            qq_reg   <= q_reg * q_reg;
            m5_reg   <= v1_reg * calib.p5;
            m6_reg   <= calib.p2 * v1_reg;
            v2a_reg  <= asr32(qq_reg, 11) * calib.p6;
            m7_reg   <= calib.p3 * asr32(qq_reg, 13);
            m5b_reg  <= m5_reg;
            m6b_reg  <= m6_reg;
            v2_reg   <= asr32(v2a_reg + (m5b_reg << 1), 2) + (calib.p4 << 16);
            w_reg    <= asr32(asr32(m7_reg, 3) + asr32(m6b_reg, 1), 18);
            m8_reg   <= (K_32768 + w_reg) * calib.p1;
            num0_reg <= (K_P_FULL - {12'd0, rp_reg[3]}) - asr32(v2_reg, 12);
            dv_reg   <= asr32(m8_reg, 15);
            pn_reg   <= num0_reg * K_P_SCALE;
            dnum_reg <= pn_reg[31] ? pn_reg : (pn_reg << 1);
            dden_reg <= dv_reg;
            dtag_reg <= {dv_reg == 32'd0, pn_reg[31]};
        end
    end

    psc_div #(
        .TAGW (2)
    ) u_div (
        .clk     (clk),
        .en      (en),
        .num     (dnum_reg),
        .den     (dden_reg),
        .tag     (dtag_reg),
        .quo     (quo),
        .tag_out (qtag)
    );

    // The p8 product uses the scaled quotient in the same stage as the square
    assign p8s  = (pq_reg >> 2) * calib.p8;
    assign corr = asr32(asr32(am_reg, 12) + asr32(m9b_reg, 13) + calib.p7, 4);

    // Post-division scaling and the second-order correction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pq_reg  <= qtag[0] ? (quo << 1) : quo;
            zq_reg  <= qtag[1];
            s_reg   <= (pq_reg >> 3) * (pq_reg >> 3);
            m9_reg  <= p8s;
            pa_reg  <= pq_reg;
            za_reg  <= zq_reg;
            am_reg  <= calib.p9 * (s_reg >> 13);
            m9b_reg <= m9_reg;
            pb_reg  <= pa_reg;
            zb_reg  <= za_reg;
            out_reg <= zb_reg ? 32'd0 : (pb_reg + corr);
        end
    end

    // Registered pressure result
    always_comb
    begin
        press = out_reg;
    end

endmodule

// ===== rtl/psc_humid.sv =====
// Humidity stages from fine temperature to the clamped Q7.10 result.
// Depends on psc_pkg.
module psc_humid
    import psc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  calib_t           calib,
    input  logic [31:0]      tf,
    input  logic [RawHW-1:0] raw_h,
    output logic [HumW-1:0]  hum
);

    logic [31:0]      x_reg, m10_reg, m11_reg, m12_reg, ha_reg, u_reg, w_reg, m13_reg;
    logic [31:0]      ha2_reg, m14_reg, ha3_reg, ha4_reg, hb_reg, xx_reg, m15_reg, xx2_reg;
    logic [31:0]      m16_reg, xx3_reg;
    logic [RawHW-1:0] rh1_reg, rh2_reg;
    logic [HumW-1:0]  hum_reg;
    logic [31:0]      ha_pre, xs, xf;

    assign ha_pre = (({16'd0, rh2_reg} << 14) - (calib.h4 << 20) - m10_reg) + K_16384;
    assign xs     = asr32(xx_reg, 15);
    assign xf     = xx3_reg - asr32(m16_reg, 4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stages 1 to 3: offset, products, first factor
            x_reg   <= tf - K_H_OFFSET;
            rh1_reg <= raw_h;
            m10_reg <= calib.h5 * x_reg;
            m11_reg <= x_reg * calib.h6;
            m12_reg <= x_reg * calib.h3;
            rh2_reg <= rh1_reg;
            ha_reg  <= asr32(ha_pre, 15);
            u_reg   <= asr32(m11_reg, 10);
            w_reg   <= asr32(m12_reg, 11) + K_32768;
            // Stages 4 to 6: second factor
            m13_reg <= u_reg * w_reg;
            ha2_reg <= ha_reg;
            m14_reg <= (asr32(m13_reg, 10) + K_H_BIAS) * calib.h2;
            ha3_reg <= ha2_reg;
            hb_reg  <= asr32(m14_reg + K_8192, 14);
            ha4_reg <= ha3_reg;
            // Stages 7 to 9: product and quadratic correction
            xx_reg  <= ha4_reg * hb_reg;
            m15_reg <= xs * xs;
            xx2_reg <= xx_reg;
            m16_reg <= asr32(m15_reg, 7) * calib.h1;
            xx3_reg <= xx2_reg;
            // Stage 10: clamp to the valid range and drop the low twelve fraction bits
            if (xf[31])
            begin
                hum_reg <= '0;
            end
            else if ($signed(xf) > $signed(K_H_MAX))
            begin
                hum_reg <= K_H_MAX[28:12];
            end
            else
            begin
                hum_reg <= xf[28:12];
            end
        end
    end

    assign hum = hum_reg;

endmodule

// ===== tb/sv/pth_sensor_compensation_chk.sv =====
// Checker for the sensor compensation block: watches both streams and the
// calibration port, predicts each result item and compares it. Needs psc_pkg.
module pth_sensor_compensation_chk
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [InTdataW-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OutTdataW-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CalibW-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [16:0] hum;
        logic [31:0] press;
        logic [31:0] tfine;
        logic [31:0] temp;
    } comp_t;

    logic [63:0] cal_temp, cal_pl, cal_ph, cal_hum;
    comp_t       comp_q[$];

    assign pending = comp_q.size();

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sign16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compensation of one raw sample set, all arithmetic modulo 2^32.
    function automatic comp_t compensate(input logic [InTdataW-1:0] d);
        comp_t       r;
        logic [31:0] ap, at, ah;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, v1, v2, tf, q, qq, p, x, ha, hb;
        ap = {12'd0, d[19:0]};
        at = {12'd0, d[39:20]};
        ah = {16'd0, d[55:40]};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = sign16(cal_temp[31:16]);
        t3 = sign16(cal_temp[47:32]);
        p9 = sign16(cal_temp[63:48]);
        p1 = {16'd0, cal_pl[15:0]};
        p2 = sign16(cal_pl[31:16]);
        p3 = sign16(cal_pl[47:32]);
        p4 = sign16(cal_pl[63:48]);
        p5 = sign16(cal_ph[15:0]);
        p6 = sign16(cal_ph[31:16]);
        p7 = sign16(cal_ph[47:32]);
        p8 = sign16(cal_ph[63:48]);
        h1 = {24'd0, cal_hum[7:0]};
        h2 = sign16(cal_hum[23:8]);
        h3 = {24'd0, cal_hum[31:24]};
        h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
        h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
        h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

        // Temperature and fine temperature.
        a = (at >> 3) - (t1 << 1);
        v1 = sra(a * t2, 11);
        b = (at >> 4) - t1;
        v2 = sra(sra(b * b, 12) * t3, 14);
        tf = v1 + v2;
        r.temp = sra(tf * 32'd5 + 32'd128, 8);
        r.tfine = tf;

        // Pressure; a zero divisor gives zero.
        v1 = sra(tf, 1) - 32'd64000;
        q = sra(v1, 2);
        qq = q * q;
        v2 = sra(qq, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sra(v2, 2) + (p4 << 16);
        v1 = sra(sra(p3 * sra(qq, 13), 3) + sra(p2 * v1, 1), 18);
        v1 = sra((32'd32768 + v1) * p1, 15);
        if (v1 == 0) begin
            p = 0;
        end
        else begin
            p = ((32'd1048576 - ap) - sra(v2, 12)) * 32'd3125;
            if (!p[31])
                p = (p << 1) / v1;
            else
                p = (p / v1) * 32'd2;
            a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            b = sra((p >> 2) * p8, 13);
            p = p + sra(a + b + p7, 4);
        end
        r.press = p;

        // Humidity, clamped before the final shift.
        x = tf - 32'd76800;
        ha = sra(((ah << 14) - (h4 << 20) - h5 * x) + 32'd16384, 15);
        hb = sra((sra(sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768), 10)
                  + 32'd2097152) * h2 + 32'd8192, 14);
        x = ha * hb;
        x = x - sra(sra(sra(x, 15) * sra(x, 15), 7) * h1, 4);
        if (x[31])
            x = 0;
        if ($signed(x) > $signed(32'h1900_0000))
            x = 32'h1900_0000;
        r.hum = x[28:12];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Calibration shadow, prediction on input and comparison on output.
    always @(posedge clk or negedge rst_n)
    begin
        comp_t exp_r;
        comp_t got_r;
        if (!rst_n)
        begin
            cal_temp = 0;
            cal_pl = 0;
            cal_ph = 0;
            cal_hum = 0;
            comp_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_r = comp_t'(m_tdata[112:0]);
                if (comp_q.size() == 0)
                begin
                    report("unexpected item", got_r.temp, 0);
                end
                else
                begin
                    exp_r = comp_q.pop_front();
                    if (got_r.temp !== exp_r.temp)
                        report("temperature", got_r.temp, exp_r.temp);
                    if (got_r.tfine !== exp_r.tfine)
                        report("fine_temperature", got_r.tfine, exp_r.tfine);
                    if (got_r.press !== exp_r.press)
                        report("pressure", got_r.press, exp_r.press);
                    if (got_r.hum !== exp_r.hum)
                        report("humidity", {15'd0, got_r.hum}, {15'd0, exp_r.hum});
                end
            end
            if (s_tvalid && s_tready)
                comp_q.push_back(compensate(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEMP:       cal_temp = cfg_data;
                    CFG_PRESS_LOW:  cal_pl = cfg_data;
                    CFG_PRESS_HIGH: cal_ph = cfg_data;
                    CFG_HUMID:      cal_hum = cfg_data;
                    default:        ;
                endcase
            end
        end
    end

endmodule

// ===== tb/sv/pth_sensor_compensation_tb.sv =====
// Top of the sensor compensation testbench: clock, reset, calibration phases,
// sample stimulus and verdict. Needs psc_pkg, the block and its checker.
module pth_sensor_compensation_tb;
    import psc_pkg::*;

    localparam int LimitCycles = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InTdataW-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutTdataW-1:0] m_tdata;
    logic                 cfg_we;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CalibW-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    bit                   hold_off;

    pth_sensor_compensation dut (.*);
    pth_sensor_compensation_chk chk (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Watchdog on total run length.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LimitCycles)
            begin
                $display("FAIL pth_sensor_compensation");
                $finish;
            end
        end
    end

    // Receiver: stalls on its own pattern, plus long hold-offs on request.
    initial
    begin
        int mode;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            mode = (cycles / 200) % 3;
            if (hold_off)
                m_tready <= 0;
            else if (mode == 0)
                m_tready <= 1;
            else if (mode == 1)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    task automatic write_cal(input cfg_idx_t idx, input logic [63:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Calibration near typical parts, or fully random, or all ones, or alternating extremes.
    task automatic set_cal(input int kind);
        logic [63:0] v[4];
        if (kind == 0)
        begin
            v[0] = {16'hFFF9, 16'd50, 16'd26435, 16'd27504};
            v[1] = {16'd2855, 16'd3024, 16'hD6D0, 16'd36477};
            v[2] = {16'hC0B8, 16'd15500, 16'hFFF9, 16'd140};
            v[3] = {8'd30, 12'd50, 12'd312, 8'd0, 16'd362, 8'd75};
        end
        else if (kind == 1)
        begin
            foreach (v[i]) v[i] = {$urandom, $urandom};
        end
        else if (kind == 2)
        begin
            foreach (v[i]) v[i] = '1;
        end
        else
        begin
            foreach (v[i]) v[i] = 64'h7FFF_8000_7FFF_8000 ^ {$urandom_range(0, 1), 63'd0};
        end
        write_cal(CFG_TEMP, v[0]);
        write_cal(CFG_PRESS_LOW, v[1]);
        write_cal(CFG_PRESS_HIGH, v[2]);
        write_cal(CFG_HUMID, v[3]);
    endtask

    // Offer one item; it holds until accepted.
    task automatic send(input logic [19:0] rp, input logic [19:0] rt,
                        input logic [15:0] rh);
        s_tvalid <= 1;
        s_tdata <= {rh, rt, rp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send($urandom, $urandom, $urandom);
                else
                    send(20'd415148 + $urandom_range(0, 200000) - 100000,
                         20'd519888 + $urandom_range(0, 100000) - 50000,
                         $urandom);
                sent++;
            end
            s_tvalid <= 0;
            repeat ($urandom_range(0, 4)) @(posedge clk);
        end
        s_tvalid <= 0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TotalLat + 10) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_we = 0;
        cfg_index = CFG_TEMP;
        cfg_data = '0;
        hold_off = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: zero calibration (zero divisor), then field extremes.
        send(0, 0, 0);
        send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        s_tvalid <= 0;
        drain();
        set_cal(0);
        send(0, 0, 0);
        send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send(20'd415148, 20'd519888, 16'd0);
        send(20'd415148, 20'd519888, 16'hFFFF);
        send(20'hAAAAA, 20'h55555, 16'hAAAA);
        send(20'h55555, 20'hAAAAA, 16'h5555);
        send(20'd415148, 20'd519888, 16'd30000);
        s_tvalid <= 0;
        drain();
        for (int k = 2; k <= 3; k++)
        begin
            set_cal(k);
            send(0, 0, 0);
            send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
            send(20'd415148, 20'd519888, 16'd30000);
            s_tvalid <= 0;
            drain();
        end

        // Random with typical calibration, with one long hold-off.
        set_cal(0);
        fork
            send_random(200);
            begin
                repeat (30) @(posedge clk);
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
        join
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            set_cal(ph % 2);
            send_random(55);
            drain();
        end

        if (fail_count == 0)
            $display("PASS pth_sensor_compensation");
        else
            $display("FAIL pth_sensor_compensation");
        $finish;
    end

endmodule
